/* sv/bmsd_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and a helper function of the sweep decoder.
package bmsd_pkg;

  localparam int unsigned MAX_CELLS_DEF  = 32;
  localparam int unsigned TEMP_SLOTS_DEF = 6;

  localparam logic [10:0] BASE_ID   = 11'h100;
  localparam logic [4:0]  REQ_COUNT = 5'd17;
  localparam logic [4:0]  TEMP_REQ  = 5'd5;
  localparam logic [4:0]  TEMP_REQ2 = 5'd6;
  localparam logic [4:0]  CELL_REQ  = 5'd7;

  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] KELVIN_OFS   = 16'd2731;
  localparam logic [12:0] CELL_MAX_MV  = 13'd4500;
  localparam logic [12:0] CELL_MIN_RST = 13'h1FFF;

  localparam logic [15:0] POLY_RST  = 16'hA001;
  localparam logic [3:0]  LIMIT_RST = 4'd4;

  localparam logic [1:0] ACT_START   = 2'd0;
  localparam logic [1:0] ACT_FRAME   = 2'd1;
  localparam logic [1:0] ACT_TIMEOUT = 2'd2;
  localparam logic [1:0] ACT_NOP     = 2'd3;

  localparam logic [1:0] KIND_REQ    = 2'd0;
  localparam logic [1:0] KIND_VALUE  = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;
  localparam logic [1:0] KIND_IGNORE = 2'd3;

  localparam logic [4:0] Q_PACK_V   = 5'd0;
  localparam logic [4:0] Q_PACK_I   = 5'd1;
  localparam logic [4:0] Q_RES_CAP  = 5'd2;
  localparam logic [4:0] Q_FULL_CAP = 5'd3;
  localparam logic [4:0] Q_CYCLES   = 5'd4;
  localparam logic [4:0] Q_SOC      = 5'd5;
  localparam logic [4:0] Q_BALANCE  = 5'd6;
  localparam logic [4:0] Q_PROTECT  = 5'd7;
  localparam logic [4:0] Q_CHG_SW   = 5'd8;
  localparam logic [4:0] Q_DSG_SW   = 5'd9;
  localparam logic [4:0] Q_STRINGS  = 5'd10;
  localparam logic [4:0] Q_SENSORS  = 5'd11;
  localparam logic [4:0] Q_TEMP     = 5'd12;
  localparam logic [4:0] Q_CELL     = 5'd13;
  localparam logic [4:0] Q_CNT      = 5'd14;
  localparam logic [4:0] Q_MIN      = 5'd15;
  localparam logic [4:0] Q_MAX      = 5'd16;
  localparam logic [4:0] Q_AVG      = 5'd17;
  localparam logic [4:0] Q_DELTA    = 5'd18;

  localparam logic [0:0] REG_POLY  = 1'd0;
  localparam logic [0:0] REG_LIMIT = 1'd1;

  // Datapath operations issued by the controller.
  localparam logic [3:0] OP_NONE     = 4'd0;
  localparam logic [3:0] OP_START    = 4'd1;  // clear sweep statistics
  localparam logic [3:0] OP_CRC_INIT = 4'd2;
  localparam logic [3:0] OP_CRC_BIT  = 4'd3;  // one shift of the CRC register
  localparam logic [3:0] OP_CRC_BYTE = 4'd4;  // xor in the next byte
  localparam logic [3:0] OP_CELL     = 4'd5;  // consider one cell word
  localparam logic [3:0] OP_LATCH_CN = 4'd6;  // latch string and sensor counts
  localparam logic [3:0] OP_DIV_INIT = 4'd7;
  localparam logic [3:0] OP_DIV_STEP = 4'd8;
  localparam logic [3:0] OP_RD_CELL  = 4'd9;  // read cell store at slot

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] byte_sel;   // byte index for CRC, or byte offset of the word for cell
    logic [4:0] slot;       // cell store read address
  } bmsd_cmd_t;

  typedef struct packed {
    logic        crc_match;
    logic [5:0]  cells_seen;
    logic [7:0]  sensor_count;
    logic [7:0]  string_count;
    logic [12:0] rd_cell;
    logic [12:0] cell_min;
    logic [12:0] cell_max;
    logic [12:0] avg;
  } bmsd_stat_t;

  function automatic logic [15:0] word_at(input logic [63:0] p, input logic [2:0] k);
    logic [5:0] sh;
    sh = 6'd48 - {k, 3'b000};
    return 16'(p >> sh);
  endfunction

endpackage

/* sv/bmsd_datapath.sv */
`timescale 1ns / 1ps
// Datapath: input item hold, CRC unit, cell store and statistics, divider.
module bmsd_datapath
  import bmsd_pkg::*;
#(
  parameter int unsigned MAX_CELLS = MAX_CELLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  logic [3:0]  len,
  input  logic [63:0] payload,
  input  logic [15:0] poly,
  input  bmsd_cmd_t   cmd,
  output bmsd_stat_t  stat,
  output logic [63:0] held_payload
);

  logic [63:0] pay_r;
  logic [3:0]  len_r;
  logic [15:0] crc_r, crc_nxt;
  logic [12:0] cell_mem [32];
  logic [12:0] rd_r;
  logic [5:0]  seen_r;
  logic [12:0] min_r, max_r;
  logic [17:0] sum_r;
  logic [7:0]  strings_r, sensors_r;
  logic [6:0]  rem_r;
  logic [17:0] quo_r;
  logic [7:0]  trial;
  logic [15:0] w;
  logic        take;
  logic [15:0] tail;

  assign w = word_at(pay_r, cmd.byte_sel);
  assign tail = word_at(pay_r, 3'(len_r - 4'd2));

  always_comb begin
    take = (w != 16'd0) && (w <= {3'b000, CELL_MAX_MV}) && (seen_r < 6'(MAX_CELLS))
           && !((strings_r != 8'd0) && ({2'b00, seen_r} >= strings_r));
  end

  always_comb begin
    crc_nxt = crc_r;
    case (cmd.op)
      OP_CRC_INIT: crc_nxt = CRC_INIT;
      OP_CRC_BYTE: crc_nxt = crc_r ^ {8'd0, pay_r[63 - {cmd.byte_sel, 3'b000} -: 8]};
      OP_CRC_BIT:  crc_nxt = crc_r[0] ? ((crc_r >> 1) ^ poly) : (crc_r >> 1);
      default:     crc_nxt = crc_r;
    endcase
  end

  // Restoring division of the 18-bit cell sum by the cell count, one bit per step.
  assign trial = {rem_r, quo_r[17]} - {2'b00, seen_r};

  always_ff @(posedge clk) begin
    if (load) begin
      pay_r <= payload;
      len_r <= (len > 4'd8) ? 4'd8 : len;
    end
    crc_r <= crc_nxt;
    if (cmd.op == OP_CELL && take) cell_mem[seen_r[4:0]] <= w[12:0];
    if (cmd.op == OP_RD_CELL) rd_r <= cell_mem[cmd.slot];
    if (cmd.op == OP_DIV_INIT) begin
      rem_r <= '0;
      quo_r <= sum_r;
    end else if (cmd.op == OP_DIV_STEP) begin
      if (!trial[7]) begin
        rem_r <= trial[6:0];
        quo_r <= {quo_r[16:0], 1'b1};
      end else begin
        rem_r <= {rem_r[5:0], quo_r[17]};
        quo_r <= {quo_r[16:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0; min_r <= CELL_MIN_RST; max_r <= '0; sum_r <= '0;
      strings_r <= '0; sensors_r <= '0;
    end else begin
      case (cmd.op)
        OP_START: begin
          seen_r <= '0; min_r <= CELL_MIN_RST; max_r <= '0; sum_r <= '0;
        end
        OP_LATCH_CN: begin
          strings_r <= pay_r[63:56];
          sensors_r <= pay_r[55:48];
        end
        OP_CELL: begin
          if (take) begin
            seen_r <= seen_r + 6'd1;
            sum_r  <= sum_r + {5'd0, w[12:0]};
            if (w[12:0] < min_r) min_r <= w[12:0];
            if (w[12:0] > max_r) max_r <= w[12:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign stat.crc_match    = (crc_r == tail);
  assign stat.cells_seen   = seen_r;
  assign stat.sensor_count = sensors_r;
  assign stat.string_count = strings_r;
  assign stat.rd_cell      = rd_r;
  assign stat.cell_min     = min_r;
  assign stat.cell_max     = max_r;
  assign stat.avg          = quo_r[12:0];
  assign held_payload      = pay_r;

endmodule

/* sv/bmsd_ctrl.sv */
`timescale 1ns / 1ps
// Controller: sequences the checks, decoding and result emission per item.
module bmsd_ctrl
  import bmsd_pkg::*;
#(
  parameter int unsigned TEMP_SLOTS = TEMP_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [10:0] in_frame_id,
  input  logic [3:0]  in_frame_length,
  input  logic [3:0]  miss_limit,
  output logic        load,
  output bmsd_cmd_t   cmd,
  input  bmsd_stat_t  stat,
  input  logic [63:0] pay,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_record_kind,
  output logic [10:0] out_request_id,
  output logic [4:0]  out_quantity,
  output logic [4:0]  out_slot,
  output logic signed [16:0] out_value,
  output logic        out_fresh,
  output logic        out_last
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DISP   = 5'd1;
  localparam logic [4:0] S_CRCB   = 5'd2;
  localparam logic [4:0] S_CRCS   = 5'd3;
  localparam logic [4:0] S_CHECK  = 5'd4;
  localparam logic [4:0] S_DEC    = 5'd5;
  localparam logic [4:0] S_CELL   = 5'd6;
  localparam logic [4:0] S_OPEN   = 5'd7;
  localparam logic [4:0] S_TCLR   = 5'd8;
  localparam logic [4:0] S_OPEN2  = 5'd9;
  localparam logic [4:0] S_RDC    = 5'd10;
  localparam logic [4:0] S_EMC    = 5'd11;
  localparam logic [4:0] S_DIVI   = 5'd12;
  localparam logic [4:0] S_DIVS   = 5'd13;
  localparam logic [4:0] S_STATS  = 5'd14;
  localparam logic [4:0] S_END    = 5'd15;
  localparam logic [4:0] S_WAIT   = 5'd16;
  localparam logic [4:0] S_LATCH  = 5'd17;

  logic [4:0]  st_r, st_nxt;
  logic [1:0]  act_r;
  logic [10:0] fid_r;
  logic [3:0]  len_r;
  logic [4:0]  idx_r, idx_nxt;
  logic        insw_r, insw_nxt;
  logic [3:0]  miss_r, miss_nxt;
  logic [4:0]  acc_r, acc_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [4:0]  slot_r, slot_nxt;
  logic [4:0]  div_r, div_nxt;

  // Output register.
  logic        ov_r;
  logic [1:0]  ok_r;
  logic [10:0] orid_r;
  logic [4:0]  oq_r, os_r;
  logic [16:0] oval_r;
  logic        ofr_r, olast_r;
  logic        emit;
  logic [1:0]  ek;
  logic [10:0] erid;
  logic [4:0]  eq, es;
  logic [16:0] ev;
  logic        efr, elast;

  logic [2:0]  gate;
  logic        abort_now;
  logic [15:0] w;
  logic [16:0] tval;
  logic [2:0]  tslot;
  logic        tok;
  logic [3:0]  nbytes;
  logic        busy_out;

  assign busy_out = ov_r && out_stall;
  assign in_stall = (st_r != S_IDLE);
  assign load     = in_valid && !in_stall;
  assign gate = (stat.sensor_count != 8'd0 && stat.sensor_count <= 8'(TEMP_SLOTS))
                ? stat.sensor_count[2:0] : 3'(TEMP_SLOTS);
  assign abort_now = miss_r >= miss_limit;
  assign nbytes = len_r - 4'd2;
  assign w = word_at(pay, {cnt_r[1:0], 1'b0});
  assign tval = {1'b0, w} - {1'b0, KELVIN_OFS};
  assign tslot = (idx_r == TEMP_REQ2) ? 3'(cnt_r + 3'd3) : cnt_r;
  assign tok = (w != 16'd0) && ($signed(tval) >= -17'sd400) && ($signed(tval) <= 17'sd1250);

  always_comb begin
    st_nxt = st_r; idx_nxt = idx_r; insw_nxt = insw_r;
    miss_nxt = miss_r; acc_nxt = acc_r; cnt_nxt = cnt_r; bit_nxt = bit_r;
    slot_nxt = slot_r; div_nxt = div_r;
    cmd = '{op: OP_NONE, byte_sel: 3'd0, slot: slot_r};
    emit = 1'b0; ek = KIND_VALUE; erid = BASE_ID + {6'd0, idx_r}; eq = '0; es = '0;
    ev = '0; efr = 1'b0; elast = 1'b0;
    case (st_r)
      S_IDLE: if (load) st_nxt = S_DISP;
      S_DISP: begin
        case (act_r)
          ACT_START: begin
            cmd.op = OP_START;
            insw_nxt = 1'b1; idx_nxt = '0; miss_nxt = '0; acc_nxt = '0;
            st_nxt = S_OPEN;
          end
          ACT_FRAME: begin
            if (!insw_r || fid_r != BASE_ID + {6'd0, idx_r} || len_r < 4'd4) begin
              st_nxt = S_CHECK;
            end else begin
              cmd.op = OP_CRC_INIT; cnt_nxt = '0; st_nxt = S_CRCB;
            end
          end
          ACT_TIMEOUT: begin
            if (insw_r) begin
              if (miss_r != 4'd15) miss_nxt = miss_r + 4'd1;
              idx_nxt = idx_r + 5'd1;
              st_nxt = S_OPEN;
            end else st_nxt = S_IDLE;
          end
          default: st_nxt = S_IDLE;
        endcase
      end
      S_CRCB: begin
        if ({1'b0, cnt_r} == nbytes) st_nxt = S_CHECK;
        else begin
          cmd.op = OP_CRC_BYTE; cmd.byte_sel = cnt_r; bit_nxt = '0; st_nxt = S_CRCS;
        end
      end
      S_CRCS: begin
        cmd.op = OP_CRC_BIT; bit_nxt = bit_r + 4'd1;
        if (bit_r == 4'd7) begin cnt_nxt = cnt_r + 3'd1; st_nxt = S_CRCB; end
      end
      S_CHECK: begin
        if (!busy_out) begin
          if (act_r != ACT_FRAME || !insw_r || fid_r != BASE_ID + {6'd0, idx_r}
              || len_r < 4'd4 || !stat.crc_match) begin
            emit = 1'b1; ek = KIND_IGNORE; erid = fid_r; elast = 1'b1; st_nxt = S_IDLE;
          end else begin
            cnt_nxt = '0; st_nxt = (idx_r == 5'd4) ? S_LATCH : S_DEC;
          end
        end
      end
      S_LATCH: begin cmd.op = OP_LATCH_CN; st_nxt = S_DEC; end
      S_DEC: begin
        if (!busy_out) begin
          case (idx_r)
            5'd0, 5'd1: begin
              emit = 1'b1;
              ev = (cnt_r == 3'd1) ? {w[15], w} : {1'b0, w};
              eq = (idx_r == 5'd0) ? 5'(Q_PACK_V + {2'd0, cnt_r})
                                   : 5'(Q_FULL_CAP + {2'd0, cnt_r});
              cnt_nxt = cnt_r + 3'd1;
              if (cnt_r == 3'd2) st_nxt = S_WAIT;
            end
            5'd2: begin
              emit = 1'b1;
              ev = cnt_r[0] ? {1'b0, pay[31:16]} : {1'b0, pay[63:48]};
              eq = cnt_r[0] ? Q_PROTECT : Q_BALANCE;
              cnt_nxt = cnt_r + 3'd1;
              if (cnt_r[0]) st_nxt = S_WAIT;
            end
            5'd3: begin
              emit = 1'b1;
              ev = cnt_r[0] ? {16'd0, pay[49]} : {16'd0, pay[48]};
              eq = cnt_r[0] ? Q_DSG_SW : Q_CHG_SW;
              cnt_nxt = cnt_r + 3'd1;
              if (cnt_r[0]) st_nxt = S_WAIT;
            end
            5'd4: begin
              emit = 1'b1;
              ev = cnt_r[0] ? {9'd0, stat.sensor_count} : {9'd0, stat.string_count};
              eq = cnt_r[0] ? Q_SENSORS : Q_STRINGS;
              cnt_nxt = cnt_r + 3'd1;
              if (cnt_r[0]) st_nxt = S_WAIT;
            end
            TEMP_REQ, TEMP_REQ2: begin
              if (cnt_r == 3'd3 || tslot >= gate) st_nxt = S_WAIT;
              else begin
                emit = tok; eq = Q_TEMP; es = {2'd0, tslot}; ev = tval;
                cnt_nxt = cnt_r + 3'd1;
              end
            end
            default: st_nxt = S_CELL;
          endcase
        end
      end
      S_CELL: begin
        cmd.op = OP_CELL; cmd.byte_sel = {cnt_r[1:0], 1'b0};
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd2) st_nxt = S_WAIT;
      end
      S_WAIT: begin
        acc_nxt = acc_r + 5'd1; miss_nxt = '0; idx_nxt = idx_r + 5'd1; st_nxt = S_OPEN;
      end
      S_OPEN: begin
        slot_nxt = {2'd0, gate};
        if (idx_r == TEMP_REQ || (abort_now && idx_r < TEMP_REQ)) st_nxt = S_TCLR;
        else st_nxt = S_OPEN2;
      end
      S_TCLR: begin
        if (slot_r >= 5'(TEMP_SLOTS)) st_nxt = S_OPEN2;
        else if (!busy_out) begin
          emit = 1'b1; erid = '0; eq = Q_TEMP; es = slot_r; slot_nxt = slot_r + 5'd1;
        end
      end
      S_OPEN2: begin
        if (abort_now || idx_r >= REQ_COUNT) begin
          slot_nxt = '0;
          st_nxt = (stat.cells_seen != 6'd0) ? S_RDC : S_END;
        end else if (!busy_out) begin
          emit = 1'b1; ek = KIND_REQ; elast = 1'b1; st_nxt = S_IDLE;
        end
      end
      S_RDC: begin cmd.op = OP_RD_CELL; st_nxt = S_EMC; end
      S_EMC: begin
        if (!busy_out) begin
          emit = 1'b1; erid = '0; eq = Q_CELL; es = slot_r; ev = {4'd0, stat.rd_cell};
          slot_nxt = slot_r + 5'd1;
          st_nxt = ({1'b0, slot_r} + 6'd1 == stat.cells_seen) ? S_DIVI : S_RDC;
        end
      end
      S_DIVI: begin cmd.op = OP_DIV_INIT; div_nxt = '0; st_nxt = S_DIVS; end
      S_DIVS: begin
        // One step per bit of the 18-bit sum.
        cmd.op = OP_DIV_STEP; div_nxt = div_r + 5'd1;
        if (div_r == 5'd17) begin slot_nxt = '0; st_nxt = S_STATS; end
      end
      S_STATS: begin
        if (!busy_out) begin
          emit = 1'b1; erid = '0; eq = 5'(Q_CNT + slot_r); slot_nxt = slot_r + 5'd1;
          case (slot_r[2:0])
            3'd0: ev = {11'd0, stat.cells_seen};
            3'd1: ev = {4'd0, stat.cell_min};
            3'd2: ev = {4'd0, stat.cell_max};
            3'd3: ev = {4'd0, stat.avg};
            default: ev = {4'd0, 13'(stat.cell_max - stat.cell_min)};
          endcase
          if (slot_r == 5'd4) st_nxt = S_END;
        end
      end
      S_END: begin
        if (!busy_out) begin
          emit = 1'b1; ek = KIND_END; erid = '0; efr = (acc_r != 5'd0); elast = 1'b1;
          insw_nxt = 1'b0; st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      act_r <= in_action; fid_r <= in_frame_id;
      len_r <= (in_frame_length > 4'd8) ? 4'd8 : in_frame_length;
    end
    cnt_r <= cnt_nxt; bit_r <= bit_nxt; slot_r <= slot_nxt; div_r <= div_nxt;
    if (emit) begin
      ok_r <= ek; orid_r <= erid; oq_r <= (ek == KIND_VALUE) ? eq : 5'd0; os_r <= es;
      oval_r <= ev; ofr_r <= efr; olast_r <= elast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; idx_r <= '0; insw_r <= 1'b0; miss_r <= '0; acc_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; idx_r <= idx_nxt; insw_r <= insw_nxt; miss_r <= miss_nxt;
      acc_r <= acc_nxt;
      if (emit) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
  end

  assign out_valid       = ov_r;
  assign out_record_kind = ok_r;
  assign out_request_id  = orid_r;
  assign out_quantity    = oq_r;
  assign out_slot        = os_r;
  assign out_value       = oval_r;
  assign out_fresh       = ofr_r;
  assign out_last        = olast_r;

endmodule

/* sv/battery_monitor_frame_sweep_decoder_top.sv */
`timescale 1ns / 1ps
// Top level of the battery monitor sweep decoder.
// An item passes through dispatch and check, a bit-serial CRC check over each
// covered byte (up to six bytes), and at end of sweep one read and one emission
// per stored cell plus a divider setup and eighteen divider steps; each result
// passes through the single output register. A new item is accepted only once
// the previous one has issued all its results.
module battery_monitor_frame_sweep_decoder_top
  import bmsd_pkg::*;
#(
  parameter int unsigned MAX_CELLS  = MAX_CELLS_DEF,
  parameter int unsigned TEMP_SLOTS = TEMP_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [10:0] in_frame_id,
  input  logic [3:0]  in_frame_length,
  input  logic [63:0] in_payload,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_record_kind,
  output logic [10:0] out_request_id,
  output logic [4:0]  out_quantity,
  output logic [4:0]  out_slot,
  output logic signed [16:0] out_value,
  output logic        out_fresh,
  output logic        out_last
);

  logic [15:0] poly_r;
  logic [3:0]  limit_r;
  logic        load;
  bmsd_cmd_t   cmd;
  bmsd_stat_t  stat;
  logic [63:0] pay;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r <= POLY_RST; limit_r <= LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POLY:  poly_r <= cfg_data;
        REG_LIMIT: limit_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  bmsd_datapath #(.MAX_CELLS(MAX_CELLS)) u_dp (
    .clk, .rst_n, .load, .len(in_frame_length), .payload(in_payload), .poly(poly_r),
    .cmd, .stat, .held_payload(pay)
  );

  bmsd_ctrl #(.TEMP_SLOTS(TEMP_SLOTS)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_action, .in_frame_id, .in_frame_length,
    .miss_limit(limit_r), .load, .cmd, .stat, .pay, .out_valid, .out_stall,
    .out_record_kind, .out_request_id, .out_quantity, .out_slot, .out_value,
    .out_fresh, .out_last
  );

endmodule

/* test/tb_battery_monitor_frame_sweep_decoder_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the battery monitor sweep decoder with its own record predictor.
module tb_battery_monitor_frame_sweep_decoder_top;
  import bmsd_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE = 300;

  typedef struct packed {
    logic [1:0]  kind;
    logic [10:0] rid;
    logic [4:0]  qty;
    logic [4:0]  slot;
    logic [16:0] value;
    logic        fresh;
    logic        last;
  } record_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_action;
  logic [10:0] in_frame_id;
  logic [3:0]  in_frame_length;
  logic [63:0] in_payload;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_record_kind;
  logic [10:0] out_request_id;
  logic [4:0]  out_quantity;
  logic [4:0]  out_slot;
  logic signed [16:0] out_value;
  logic        out_fresh;
  logic        out_last;

  battery_monitor_frame_sweep_decoder_top i_dut (.*);

  // Predictor state.
  logic [15:0] crc_poly;
  int          miss_limit;
  int          req_idx;
  bit          sweeping;
  int          miss_run;
  int          accepted;
  int          sensors;
  int          strings;
  int          cell_mv[32];
  int          n_cells;
  int          cell_lo;
  int          cell_hi;
  int          cell_total;

  record_t expected_records[$];
  record_t new_records[$];
  int      items_sent;
  int      sweeps_done;
  int      records_checked;
  int      mismatches;
  int      cycles;
  int      stall_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d records outstanding", cycles,
               expected_records.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver stalls: mostly short bursts, sometimes long, with stall-free stretches.
  always @(posedge clk) begin
    int r;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_stall <= 1'b0;
        stall_hold <= $urandom_range(0, 20);
      end else if (r < 95) begin
        out_stall <= 1'b1;
        stall_hold <= $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b1;
        stall_hold <= $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    record_t got, exp_rec;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_record_kind, out_request_id, out_quantity, out_slot, out_value,
              out_fresh, out_last};
      records_checked++;
      if (expected_records.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected record kind %0d id %h qty %0d slot %0d value %0d",
                   got.kind, got.rid, got.qty, got.slot, $signed(got.value));
      end else begin
        exp_rec = expected_records.pop_front();
        if (got !== exp_rec) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Mismatch: expected kind %0d id %h qty %0d slot %0d value %0d ",
                      "fresh %0d last %0d, got kind %0d id %h qty %0d slot %0d ",
                      "value %0d fresh %0d last %0d"},
                     exp_rec.kind, exp_rec.rid, exp_rec.qty, exp_rec.slot,
                     $signed(exp_rec.value), exp_rec.fresh, exp_rec.last,
                     got.kind, got.rid, got.qty, got.slot, $signed(got.value),
                     got.fresh, got.last);
        end
      end
    end
  end

  function automatic logic [7:0] byte_of(logic [63:0] p, int k);
    return p[63 - 8 * (k & 7) -: 8];
  endfunction

  function automatic int word_of(logic [63:0] p, int k);
    return {byte_of(p, k), byte_of(p, k + 1)};
  endfunction

  function automatic int as_signed16(int w);
    return (w >= 32768) ? w - 65536 : w;
  endfunction

  function automatic logic [15:0] frame_crc(logic [63:0] p, int n, logic [15:0] poly);
    logic [15:0] crc;
    crc = CRC_INIT;
    for (int k = 0; k < n; k++) begin
      crc ^= {8'h00, byte_of(p, k)};
      for (int b = 0; b < 8; b++)
        crc = crc[0] ? ((crc >> 1) ^ poly) : (crc >> 1);
    end
    return crc;
  endfunction

  function automatic logic [63:0] four_words(int w0, int w1, int w2, int w3);
    return {w0[15:0], w1[15:0], w2[15:0], w3[15:0]};
  endfunction

  function automatic void emit(logic [1:0] kind, int rid, logic [4:0] qty, int slot,
                               int value, bit fresh);
    record_t r;
    r = '{kind, rid[10:0], qty, slot[4:0], value[16:0], fresh, 1'b0};
    new_records.push_back(r);
  endfunction

  function automatic int temp_gate();
    return (sensors > 0 && sensors <= TEMP_SLOTS_DEF) ? sensors : TEMP_SLOTS_DEF;
  endfunction

  function automatic void close_sweep();
    if (n_cells > 0) begin
      for (int i = 0; i < n_cells; i++) emit(KIND_VALUE, 0, Q_CELL, i, cell_mv[i], 0);
      emit(KIND_VALUE, 0, Q_CNT, 0, n_cells, 0);
      emit(KIND_VALUE, 0, Q_MIN, 0, cell_lo, 0);
      emit(KIND_VALUE, 0, Q_MAX, 0, cell_hi, 0);
      emit(KIND_VALUE, 0, Q_AVG, 0, cell_total / n_cells, 0);
      emit(KIND_VALUE, 0, Q_DELTA, 0, cell_hi - cell_lo, 0);
    end
    emit(KIND_END, 0, Q_PACK_V, 0, 0, accepted > 0);
    sweeping = 0;
    sweeps_done++;
  endfunction

  function automatic void open_request();
    bit abort_now;
    abort_now = miss_run >= miss_limit;
    if (req_idx == TEMP_REQ || (abort_now && req_idx < TEMP_REQ))
      for (int s = temp_gate(); s < TEMP_SLOTS_DEF; s++) emit(KIND_VALUE, 0, Q_TEMP, s, 0, 0);
    if (abort_now || req_idx >= REQ_COUNT) close_sweep();
    else emit(KIND_REQ, BASE_ID + req_idx, Q_PACK_V, 0, 0, 0);
  endfunction

  function automatic void decode_reply(logic [63:0] p);
    int rid, w, t, slot;
    rid = BASE_ID + req_idx;
    case (req_idx)
      0: begin
        emit(KIND_VALUE, rid, Q_PACK_V, 0, word_of(p, 0), 0);
        emit(KIND_VALUE, rid, Q_PACK_I, 0, as_signed16(word_of(p, 2)), 0);
        emit(KIND_VALUE, rid, Q_RES_CAP, 0, word_of(p, 4), 0);
      end
      1: begin
        emit(KIND_VALUE, rid, Q_FULL_CAP, 0, word_of(p, 0), 0);
        emit(KIND_VALUE, rid, Q_CYCLES, 0, as_signed16(word_of(p, 2)), 0);
        emit(KIND_VALUE, rid, Q_SOC, 0, word_of(p, 4), 0);
      end
      2: begin
        emit(KIND_VALUE, rid, Q_BALANCE, 0, word_of(p, 0), 0);
        emit(KIND_VALUE, rid, Q_PROTECT, 0, word_of(p, 4), 0);
      end
      3: begin
        w = word_of(p, 0);
        emit(KIND_VALUE, rid, Q_CHG_SW, 0, w & 1, 0);
        emit(KIND_VALUE, rid, Q_DSG_SW, 0, (w >> 1) & 1, 0);
      end
      4: begin
        strings = byte_of(p, 0);
        sensors = byte_of(p, 1);
        emit(KIND_VALUE, rid, Q_STRINGS, 0, strings, 0);
        emit(KIND_VALUE, rid, Q_SENSORS, 0, sensors, 0);
      end
      5, 6: begin
        for (int i = 0; i < 3; i++) begin
          slot = (req_idx - TEMP_REQ) * 3 + i;
          if (slot >= temp_gate()) break;
          w = word_of(p, 2 * i);
          if (w == 0) continue;
          t = w - KELVIN_OFS;
          if (t >= -400 && t <= 1250) emit(KIND_VALUE, rid, Q_TEMP, slot, t, 0);
        end
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          if (strings > 0 && n_cells >= strings) break;
          if (n_cells >= MAX_CELLS_DEF) break;
          w = word_of(p, 2 * i);
          if (w > 0 && w <= CELL_MAX_MV) begin
            cell_mv[n_cells] = w;
            n_cells++;
            cell_total += w;
            if (w < cell_lo) cell_lo = w;
            if (w > cell_hi) cell_hi = w;
          end
        end
      end
    endcase
  endfunction

  // Works out every record that one accepted item causes and queues them.
  function automatic void predict_item(logic [1:0] act, logic [10:0] fid, logic [3:0] len_code,
                                       logic [63:0] p);
    int len;
    len = (len_code > 8) ? 8 : len_code;
    new_records.delete();
    if (act == ACT_START) begin
      sweeping = 1;
      req_idx = 0;
      miss_run = 0;
      accepted = 0;
      n_cells = 0;
      cell_lo = CELL_MIN_RST;
      cell_hi = 0;
      cell_total = 0;
      open_request();
    end else if (act == ACT_FRAME) begin
      if (!sweeping || fid != BASE_ID + req_idx || len < 4 ||
          frame_crc(p, len - 2, crc_poly) != word_of(p, len - 2)) begin
        emit(KIND_IGNORE, fid, Q_PACK_V, 0, 0, 0);
      end else begin
        decode_reply(p);
        accepted = (accepted + 1) & 31;
        miss_run = 0;
        req_idx++;
        open_request();
      end
    end else if (act == ACT_TIMEOUT && sweeping) begin
      if (miss_run < 15) miss_run++;
      req_idx++;
      open_request();
    end
    if (new_records.size() > 0) new_records[new_records.size() - 1].last = 1'b1;
    foreach (new_records[i]) expected_records.push_back(new_records[i]);
  endfunction

  task automatic send_item(logic [1:0] act, logic [10:0] fid, logic [3:0] len_code,
                           logic [63:0] p);
    int r, gap;
    in_valid <= 1'b1;
    in_action <= act;
    in_frame_id <= fid;
    in_frame_length <= len_code;
    in_payload <= p;
    do @(posedge clk); while (in_stall);
    predict_item(act, fid, len_code, p);
    items_sent++;
    r = $urandom_range(0, 99);
    gap = (r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // A reply to the open request, with a correct checksum ahead of the given length.
  task automatic send_reply(logic [63:0] body, logic [3:0] len_code);
    int n;
    logic [15:0] crc;
    n = ((len_code > 8) ? 8 : len_code) - 2;
    crc = frame_crc(body, n, crc_poly);
    body[63 - 8 * n -: 8] = crc[15:8];
    body[63 - 8 * (n + 1) -: 8] = crc[7:0];
    send_item(ACT_FRAME, 11'(BASE_ID + req_idx), len_code, body);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] data);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_POLY) crc_poly = data;
    else miss_limit = data[3:0];
  endtask

  function automatic logic [63:0] random_body();
    logic [63:0] p;
    int w[3];
    p = {$urandom, $urandom};
    case (req_idx)
      4: begin
        case ($urandom_range(0, 3))
          0: p[63:56] = '0;
          1: p[63:56] = 8'($urandom_range(1, 33));
          default: ;
        endcase
        if ($urandom_range(0, 3) != 0) p[55:48] = 8'($urandom_range(0, 7));
      end
      5, 6: begin
        for (int i = 0; i < 3; i++) begin
          case ($urandom_range(0, 5))
            0: w[i] = 0;
            1: w[i] = $urandom_range(0, 65535);
            default: w[i] = $urandom_range(2331, 3981) + (($urandom_range(0, 9) == 0) ? 1 : 0);
          endcase
          p[63 - 16 * i -: 16] = 16'(w[i]);
        end
      end
      default: if (req_idx >= CELL_REQ) begin
        for (int i = 0; i < 3; i++) begin
          case ($urandom_range(0, 7))
            0: w[i] = 0;
            1: w[i] = $urandom_range(4501, 65535);
            default: w[i] = $urandom_range(1, 4500);
          endcase
          p[63 - 16 * i -: 16] = 16'(w[i]);
        end
      end
    endcase
    return p;
  endfunction

  function automatic logic [3:0] random_len();
    int r;
    r = $urandom_range(0, 9);
    return (r < 7) ? 4'd8 : (r < 9) ? 4'($urandom_range(4, 7)) : 4'($urandom_range(9, 15));
  endfunction

  task automatic test_directed_frames();
    // Frames, timeouts and the unused action outside a sweep.
    send_item(ACT_FRAME, BASE_ID, 4'd8, 64'h0);
    send_item(ACT_TIMEOUT, 11'h7FF, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(ACT_NOP, 11'h000, 4'd15, 64'h0);
    send_item(ACT_START, 0, 0, 0);
    send_reply(four_words(16'hFFFF, 16'h8000, 16'h0000, 0), 4'd8);
    // Bad checksum, wrong id and short length leave the request open.
    send_item(ACT_FRAME, 11'(BASE_ID + req_idx), 4'd8, 64'h0123_4567_89AB_CDEF);
    send_item(ACT_FRAME, 11'h7FF, 4'd8, 64'h0);
    send_reply(64'h0, 4'd3);
    send_reply(four_words(16'h0001, 16'h7FFF, 16'hFFFF, 0), 4'd15);
    send_reply(four_words(16'hABCD, 0, 16'h1234, 0), 4'd4);
    send_reply(four_words(16'h0003, 0, 0, 0), 4'd8);
    send_reply({8'd2, 8'd4, 48'h0}, 4'd8);
    // Zero raw, lowest and highest in-range temperatures; slot three is just out of range.
    send_reply(four_words(0, 2331, 3981, 0), 4'd8);
    send_reply(four_words(3982, 3000, 3000, 0), 4'd8);
    send_reply(four_words(0, 1, 4500, 0), 4'd8);
    send_reply(four_words(4501, 777, 888, 0), 4'd8);
    repeat (4) send_item(ACT_TIMEOUT, 0, 0, 0);
    // A start in the middle of a sweep restarts it.
    send_item(ACT_START, 0, 0, 0);
    send_reply(four_words(1, 2, 3, 0), 4'd8);
    send_item(ACT_START, 0, 0, 0);
    while (sweeping) send_item(ACT_TIMEOUT, 0, 0, 0);
  endtask

  task automatic test_miss_abort();
    write_reg(REG_LIMIT, 16'd1);
    send_item(ACT_START, 0, 0, 0);
    send_item(ACT_TIMEOUT, 0, 0, 0);
    write_reg(REG_LIMIT, 16'd0);
    send_item(ACT_START, 0, 0, 0);
    write_reg(REG_LIMIT, 16'd15);
    send_item(ACT_START, 0, 0, 0);
    while (sweeping) send_item(ACT_TIMEOUT, 0, 0, 0);
    write_reg(REG_LIMIT, 16'd4);
  endtask

  task automatic random_sweep();
    int r;
    send_item(ACT_START, 0, 0, 0);
    while (sweeping) begin
      r = $urandom_range(0, 99);
      if (r < 72) send_reply(random_body(), random_len());
      else if (r < 84)
        send_item(ACT_TIMEOUT, 11'($urandom), 4'($urandom), {$urandom, $urandom});
      else if (r < 88)
        send_item(ACT_FRAME, 11'(BASE_ID + req_idx), 4'($urandom), {$urandom, $urandom});
      else if (r < 92)
        send_item(ACT_FRAME, 11'($urandom), 4'($urandom), {$urandom, $urandom});
      else if (r < 95) send_reply(random_body(), 4'($urandom_range(0, 3)));
      else if (r < 98)
        send_item(ACT_NOP, 11'($urandom), 4'($urandom), {$urandom, $urandom});
      else send_item(ACT_START, 0, 0, 0);
    end
    if ($urandom_range(0, 2) == 0) send_item(ACT_TIMEOUT, 0, 0, 0);
  endtask

  task automatic test_random_sweeps();
    logic [15:0] polys[4];
    polys = '{16'hA001, 16'h0000, 16'hFFFF, 16'h8408};
    while (items_sent < 400) begin
      if ($urandom_range(0, 3) == 0) begin
        write_reg(REG_POLY, $urandom_range(0, 4) == 0 ? 16'($urandom) : polys[$urandom_range(0, 3)]);
        write_reg(REG_LIMIT, 16'($urandom_range(1, 15)));
      end
      random_sweep();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_POLY;
    cfg_data = '0;
    in_valid = 1'b0;
    in_action = ACT_START;
    in_frame_id = '0;
    in_frame_length = '0;
    in_payload = '0;
    cycles = 0;
    items_sent = 0;
    sweeps_done = 0;
    records_checked = 0;
    mismatches = 0;
    crc_poly = 16'hA001;
    miss_limit = 4;
    req_idx = 0;
    sweeping = 0;
    miss_run = 0;
    accepted = 0;
    sensors = 0;
    strings = 0;
    n_cells = 0;
    cell_lo = CELL_MIN_RST;
    cell_hi = 0;
    cell_total = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (SETTLE) @(posedge clk);

    test_directed_frames();
    test_miss_abort();
    write_reg(REG_POLY, 16'hFFFF);
    write_reg(REG_POLY, 16'h0000);
    random_sweep();
    write_reg(REG_POLY, 16'hA001);
    test_random_sweeps();
    wait_idle();

    $display("Sent %0d items over %0d sweeps; %0d records checked, %0d mismatches.",
             items_sent, sweeps_done, records_checked, mismatches);
    if (mismatches == 0 && expected_records.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/bmsd_pkg.sv
sv/bmsd_datapath.sv
sv/bmsd_ctrl.sv
sv/battery_monitor_frame_sweep_decoder_top.sv
test/tb_battery_monitor_frame_sweep_decoder_top.sv
